>>> sv/lfra_pkg.sv
package lfra_pkg;

  // sizes of the cell bitmap and of the allocation table
  localparam int MEM_CELLS    = 4096;
  localparam int MAX_REQUESTS = 1024;

  // fixed widths of the word fields
  localparam int LEN_W   = 13;
  localparam int ID_W    = 11;
  localparam int START_W = 13;

  // derived widths
  localparam int ADDR_W   = $clog2(MEM_CELLS);
  localparam int CNT_W    = $clog2(MEM_CELLS + 1);
  localparam int SLOT_W   = $clog2(MAX_REQUESTS);
  localparam int CLR_N    = (MEM_CELLS > MAX_REQUESTS) ? MEM_CELLS : MAX_REQUESTS;
  localparam int CLR_W    = $clog2(CLR_N);

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // one record of the allocation table
  typedef struct packed {
    logic              live;
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] last;
  } alloc_rec_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MARK,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_FREE_CLR,
    ST_DONE
  } state_t;

endpackage

>>> sv/largest_free_run_allocator.sv
// Worst-fit allocator over a bitmap of MEM_CELLS cells held in a one-bit-wide
// synchronous RAM, with a table of MAX_REQUESTS allocation records in a second
// RAM. After reset a clearing pass over max(MEM_CELLS, MAX_REQUESTS) addresses
// (4096) runs with in_stall high. An allocate word reads the bitmap one cell a
// cycle, takes a decision state and then marks the granted cells used one cell
// a cycle (none on a failure); its result word follows the marking, and the
// next word can be taken in the cycle after the result is loaded. A free word
// looks up its record in ST_FREE_RD and ST_FREE_CHK, then clears the cells it
// releases one a cycle, and gives no result. One word is worked on at a time;
// a finished result sits in an output register so the next word can be taken
// while it waits on out_stall.
module largest_free_run_allocator
  import lfra_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [LEN_W-1:0]   length,
  input  logic [ID_W-1:0]    request_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               failed,
  output logic [START_W-1:0] start_address
);

  // memories
  logic       cell_mem [MEM_CELLS];
  alloc_rec_t alloc_mem [MAX_REQUESTS];

  state_t state, state_next;

  // control and datapath registers
  logic [CLR_W-1:0]  clr_addr;
  logic [SLOT_W-1:0] seq_slot;
  logic [SLOT_W-1:0] req_slot;
  logic [SLOT_W-1:0] free_slot;
  logic [LEN_W-1:0]  req_len;
  logic [ADDR_W-1:0] scan_addr;
  logic              scan_issue;
  logic              scan_vld;
  logic [ADDR_W-1:0] scan_pos;
  logic              cell_q;
  alloc_rec_t        alloc_q;
  logic [CNT_W-1:0]  run_len;
  logic [ADDR_W-1:0] run_start;
  logic [CNT_W-1:0]  best_len;
  logic [ADDR_W-1:0] best_start;
  logic [LEN_W-1:0]  mark_left;
  logic [ADDR_W-1:0] mark_ptr;
  logic [ADDR_W-1:0] free_ptr;
  logic [ADDR_W-1:0] free_end;
  logic              res_fail;

  // combinational controls
  logic              accept;
  logic              id_ok;
  logic              grant;
  logic              res_load;
  logic [ADDR_W-1:0] grant_end;
  logic              cell_we;
  logic [ADDR_W-1:0] cell_waddr;
  logic              cell_wbit;
  logic              alloc_we;
  logic [SLOT_W-1:0] alloc_waddr;
  alloc_rec_t        alloc_wdata;
  logic [ADDR_W:0]   start_plus;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign id_ok     = (request_id != '0) && (32'(request_id) <= MAX_REQUESTS);
  assign grant     = (req_len != '0) && (32'(best_len) >= 32'(req_len));
  assign grant_end = ADDR_W'(32'(best_start) + 32'(req_len) - 32'd1);
  assign res_load  = (state == ST_DONE) && (!out_valid || !out_stall);
  assign start_plus = {1'b0, best_start} + (ADDR_W+1)'(1);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory write controls
  always_comb begin
    state_next  = state;
    cell_we     = 1'b0;
    cell_waddr  = mark_ptr;
    cell_wbit   = 1'b0;
    alloc_we    = 1'b0;
    alloc_waddr = req_slot;
    alloc_wdata = '0;
    case (state)
      ST_CLEAR: begin
        cell_we     = (32'(clr_addr) < MEM_CELLS);
        cell_waddr  = ADDR_W'(clr_addr);
        alloc_we    = (32'(clr_addr) < MAX_REQUESTS);
        alloc_waddr = SLOT_W'(clr_addr);
        if (32'(clr_addr) == CLR_N - 1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (command == CMD_ALLOC) begin
            state_next = ST_SCAN;
          end else if (id_ok) begin
            state_next = ST_FREE_RD;
          end
        end
      end
      ST_SCAN: begin
        if (scan_vld && (32'(scan_pos) == MEM_CELLS - 1)) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (grant) begin
          alloc_we          = 1'b1;
          alloc_waddr       = req_slot;
          alloc_wdata.live  = 1'b1;
          alloc_wdata.first = best_start;
          alloc_wdata.last  = grant_end;
          state_next        = ST_MARK;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_MARK: begin
        cell_we    = 1'b1;
        cell_waddr = mark_ptr;
        cell_wbit  = 1'b1;
        if (mark_left == LEN_W'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_FREE_RD: begin
        state_next = ST_FREE_CHK;
      end
      ST_FREE_CHK: begin
        if (alloc_q.live) begin
          alloc_we          = 1'b1;
          alloc_waddr       = free_slot;
          alloc_wdata       = alloc_q;
          alloc_wdata.live  = 1'b0;
          state_next        = ST_FREE_CLR;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FREE_CLR: begin
        cell_we    = 1'b1;
        cell_waddr = free_ptr;
        cell_wbit  = 1'b0;
        if (free_ptr == free_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (res_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // cell bitmap ram
  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wbit;
    end
    cell_q <= cell_mem[scan_addr];
  end

  // allocation record ram
  always_ff @(posedge clk) begin
    if (alloc_we) begin
      alloc_mem[alloc_waddr] <= alloc_wdata;
    end
    alloc_q <= alloc_mem[free_slot];
  end

  // clearing pass counter and sequence slot
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      seq_slot <= '0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + CLR_W'(1);
      end
      if (accept) begin
        if (32'(seq_slot) == MAX_REQUESTS - 1) begin
          seq_slot <= '0;
        end else begin
          seq_slot <= seq_slot + SLOT_W'(1);
        end
      end
    end
  end

  // read issue for the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_issue <= 1'b0;
      scan_vld   <= 1'b0;
    end else begin
      scan_vld <= scan_issue;
      if (accept && command == CMD_ALLOC) begin
        scan_issue <= 1'b1;
      end else if (scan_issue && (32'(scan_addr) == MEM_CELLS - 1)) begin
        scan_issue <= 1'b0;
      end
    end
  end

  // word capture, run tracking, marking and freeing pointers
  always_ff @(posedge clk) begin
    scan_pos <= scan_addr;
    if (accept) begin
      req_len    <= length;
      req_slot   <= seq_slot;
      free_slot  <= SLOT_W'(request_id - ID_W'(1));
      scan_addr  <= '0;
      run_len    <= '0;
      run_start  <= '0;
      best_len   <= '0;
      best_start <= '0;
    end else if (scan_issue) begin
      scan_addr <= scan_addr + ADDR_W'(1);
    end

    // longest free run, lowest start wins a tie
    if (state == ST_SCAN && scan_vld) begin
      if (!cell_q) begin
        if (run_len == '0) begin
          run_start <= scan_pos;
        end
        run_len <= run_len + CNT_W'(1);
        if (run_len + CNT_W'(1) > best_len) begin
          best_len   <= run_len + CNT_W'(1);
          best_start <= (run_len == '0) ? scan_pos : run_start;
        end
      end else begin
        run_len <= '0;
      end
    end

    if (state == ST_DECIDE) begin
      res_fail  <= !grant;
      mark_ptr  <= best_start;
      mark_left <= req_len;
    end
    if (state == ST_MARK) begin
      mark_ptr  <= mark_ptr + ADDR_W'(1);
      mark_left <= mark_left - LEN_W'(1);
    end

    if (state == ST_FREE_CHK) begin
      free_ptr <= alloc_q.first;
      free_end <= alloc_q.last;
    end else if (state == ST_FREE_CLR) begin
      free_ptr <= free_ptr + ADDR_W'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      failed        <= res_fail;
      start_address <= res_fail ? '0 : START_W'(start_plus);
    end
  end

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lfra_pkg::*;

  // clock, reset and block ports
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               command = CMD_ALLOC;
  logic [LEN_W-1:0]   length = '0;
  logic [ID_W-1:0]    request_id = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               failed;
  logic [START_W-1:0] start_address;

  largest_free_run_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .length        (length),
    .request_id    (request_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .failed        (failed),
    .start_address (start_address)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one expected result word
  typedef struct {
    logic               refused;
    logic [START_W-1:0] first_cell;
  } grant_t;

  grant_t grants_due[$];

  // shadow copy of the allocator state
  bit          cell_busy [MEM_CELLS];
  int unsigned blk_first [MAX_REQUESTS];
  int unsigned blk_last  [MAX_REQUESTS];
  bit          blk_live  [MAX_REQUESTS];
  int unsigned seq_no = 1;

  // run statistics
  int errors    = 0;
  int granted   = 0;
  int refused   = 0;
  int releases  = 0;
  int ignored   = 0;
  int wraps     = 0;

  // idling controls
  bit no_idle  = 1'b0;
  bit hold_out = 1'b0;
  int stall_left = 0;

  // gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    if (no_idle)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 200);
  endfunction

  // apply one accepted word to the shadow state, queue the expected grant
  function automatic void bitmap_step(logic cmd, logic [LEN_W-1:0] len,
                                      logic [ID_W-1:0] id);
    int unsigned best_len, best_first, run_len, run_first, slot, k;
    grant_t g;
    slot = (seq_no - 1) % MAX_REQUESTS;
    if (cmd == CMD_ALLOC) begin
      best_len = 0;
      best_first = 0;
      run_len = 0;
      run_first = 0;
      // longest free run, first one wins a tie
      for (int pos = 0; pos < MEM_CELLS; pos++) begin
        if (!cell_busy[pos]) begin
          if (run_len == 0)
            run_first = pos;
          run_len++;
          if (run_len > best_len) begin
            best_len = run_len;
            best_first = run_first;
          end
        end else begin
          run_len = 0;
        end
      end
      if (len == 0 || best_len < len) begin
        g.refused = 1'b1;
        g.first_cell = '0;
      end else begin
        for (int unsigned p = best_first; p < best_first + len; p++)
          cell_busy[p] = 1'b1;
        blk_first[slot] = best_first;
        blk_last[slot] = best_first + len - 1;
        blk_live[slot] = 1'b1;
        g.refused = 1'b0;
        g.first_cell = START_W'(best_first + 1);
      end
      grants_due = {grants_due, g};
    end else if (id >= 1 && id <= MAX_REQUESTS && blk_live[id - 1]) begin
      k = id - 1;
      for (int unsigned p = blk_first[k]; p <= blk_last[k] && p < MEM_CELLS; p++)
        cell_busy[p] = 1'b0;
      blk_live[k] = 1'b0;
      releases++;
    end else begin
      ignored++;
    end
    if (seq_no >= MAX_REQUESTS) begin
      seq_no = 1;
      wraps++;
    end else begin
      seq_no++;
    end
  endfunction

  // send one word; tag returns the sequence number it was given
  task automatic send_word(input logic cmd, input logic [LEN_W-1:0] len,
                           input logic [ID_W-1:0] id, output int unsigned tag);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    length     <= len;
    request_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tag = seq_no;
    bitmap_step(cmd, len, id);
  endtask

  // result side: compare each word, then pick the next stall
  always @(posedge clk) begin : result_side
    grant_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (grants_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, failed=%0b start_address=%0d",
                   $time, failed, start_address);
        end else begin
          want = grants_due.pop_front();
          if (want.refused) refused++;
          else granted++;
          if (failed !== want.refused) begin
            errors++;
            $display("%0t: failed expected %0b actual %0b",
                     $time, want.refused, failed);
          end
          if (start_address !== want.first_cell) begin
            errors++;
            $display("%0t: start_address expected %0d actual %0d",
                     $time, want.first_cell, start_address);
          end
        end
      end
      if (stall_left == 0 && $urandom_range(0, 3) == 0)
        stall_left = idle_len();
      if (hold_out) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // bad lengths on an empty memory
  task automatic test_refusals();
    int unsigned t;
    send_word(CMD_ALLOC, 13'd0, 11'd0, t);
    send_word(CMD_ALLOC, 13'h1fff, 11'h7ff, t);
    send_word(CMD_ALLOC, 13'd4097, 11'd0, t);
  endtask

  // whole memory in one block, then the very last cell
  task automatic test_whole_memory();
    int unsigned full_tag, head_tag, tail_tag, t;
    send_word(CMD_ALLOC, 13'd4096, 11'd0, full_tag);
    send_word(CMD_ALLOC, 13'd1, 11'd0, t);
    send_word(CMD_FREE, 13'd0, ID_W'(full_tag), t);
    send_word(CMD_FREE, 13'd0, ID_W'(full_tag), t);
    send_word(CMD_ALLOC, 13'd4095, 11'd0, head_tag);
    send_word(CMD_ALLOC, 13'd1, 11'd0, tail_tag);
    send_word(CMD_FREE, 13'h1fff, ID_W'(tail_tag), t);
    send_word(CMD_FREE, 13'd0, ID_W'(head_tag), t);
  endtask

  // longest run wins, lowest start on a tie, unknown numbers do nothing
  task automatic test_worst_fit();
    int unsigned seqs [8];
    int unsigned t;
    send_word(CMD_ALLOC, 13'd100, 11'd0, seqs[0]);
    send_word(CMD_ALLOC, 13'd50, 11'd0, seqs[1]);
    send_word(CMD_ALLOC, 13'd100, 11'd0, seqs[2]);
    send_word(CMD_ALLOC, 13'd50, 11'd0, seqs[3]);
    send_word(CMD_FREE, 13'd0, ID_W'(seqs[0]), t);
    send_word(CMD_FREE, 13'd0, ID_W'(seqs[2]), t);
    send_word(CMD_ALLOC, 13'd3796, 11'd0, seqs[4]);
    send_word(CMD_ALLOC, 13'd60, 11'd0, seqs[5]);
    send_word(CMD_ALLOC, 13'd100, 11'd0, seqs[6]);
    send_word(CMD_FREE, 13'd0, 11'd0, t);
    send_word(CMD_FREE, 13'd0, 11'd1025, t);
    send_word(CMD_FREE, 13'd0, 11'h7ff, t);
    send_word(CMD_FREE, 13'd0, 11'd1000, t);
    for (int i = 1; i < 7; i++)
      if (i != 2)
        send_word(CMD_FREE, 13'd0, ID_W'(seqs[i]), t);
  endtask

  // next allocate completes while the previous result is held
  task automatic test_output_hold();
    int unsigned first_tag, second_tag, t;
    hold_out <= 1'b1;
    send_word(CMD_ALLOC, 13'd7, 11'd0, first_tag);
    send_word(CMD_ALLOC, 13'd9, 11'd0, second_tag);
    hold_out <= 1'b0;
    send_word(CMD_FREE, 13'd0, ID_W'(first_tag), t);
    send_word(CMD_FREE, 13'd0, ID_W'(second_tag), t);
  endtask

  // random mix of allocates and releases of live blocks, some noise frees
  task automatic test_random_mix();
    int counted, r, pick;
    int unsigned t;
    int unsigned held[$];
    logic [LEN_W-1:0] len;
    counted = 0;
    while (counted < 108) begin
      no_idle = (counted >= 45 && counted < 70);
      r = $urandom_range(0, 99);
      held.delete();
      for (int k = 0; k < MAX_REQUESTS; k++)
        if (blk_live[k])
          held = {held, k + 1};
      if (r < 85 && r >= 55 && held.size() > 0) begin
        pick = $urandom_range(0, held.size() - 1);
        send_word(CMD_FREE, LEN_W'($urandom), ID_W'(held[pick]), t);
        counted++;
      end else if (r >= 85) begin
        send_word(CMD_FREE, LEN_W'($urandom), ID_W'($urandom_range(0, 2047)), t);
        counted++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65)
          len = LEN_W'($urandom_range(1, 24));
        else if (pick < 85)
          len = LEN_W'($urandom_range(25, 400));
        else if (pick < 92)
          len = LEN_W'($urandom_range(401, MEM_CELLS));
        else if (pick < 97)
          len = LEN_W'($urandom_range(MEM_CELLS + 1, 8191));
        else
          len = '0;
        send_word(CMD_ALLOC, len, ID_W'($urandom), t);
        counted++;
      end
    end
    no_idle = 1'b0;
  endtask

  // test sequence
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_refusals();
    test_whole_memory();
    test_worst_fit();
    test_output_hold();
    test_random_mix();
    in_valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (2 * MEM_CELLS + 64) @(posedge clk);
    $display("tb: %0d allocate results (%0d granted, %0d refused), %0d blocks released",
             granted + refused, granted, refused, releases);
    $display("tb: %0d frees ignored, sequence number wrapped %0d time(s)", ignored, wraps);
    if (errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
